FILE: src/distance_vector_route_table_defines.svh
// Assertion macros for the distance-vector route table.
// Included by the top level; no other dependencies.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define DVRT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DVRT_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DVRT_ASSERT(label, clk, rst, prop, msg)
`define DVRT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: src/dvrt_pkg.sv
// Package for the distance-vector route table: sizes, command codes, types.
// No dependencies.
`timescale 1ns / 1ps
package dvrt_pkg;
   localparam int NODES = 8;
   localparam int NW = 3;
   localparam int CW = 16;
   localparam logic [CW-1:0] SAT_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      CMD_LOAD = 3'd0, CMD_HEADER = 3'd1, CMD_ENTRY = 3'd2, CMD_SET = 3'd3,
      CMD_DISABLE = 3'd4, CMD_TICK = 3'd5, CMD_STEP = 3'd6, CMD_READ = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ACK = 2'd0, KIND_ERR = 2'd1, KIND_ROUTE = 2'd2, KIND_ADV = 2'd3
   } kind_type;

   localparam logic [1:0] REG_SELF = 2'd0;
   localparam logic [1:0] REG_INF = 2'd1;
   localparam logic [1:0] REG_LIMIT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_RELAX2, ST_TICK, ST_FALL, ST_STEP, ST_OUT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic       latch;    // capture request fields
      logic       exec;     // single-cycle command effect
      logic       relax2;   // second half of entry relaxation
      logic       tick_ent; // tick on entry idx
      logic       fall_ent; // fallback of entry idx onto down link
      logic       step_ent; // present known cost of entry idx
      logic [NW-1:0] idx;
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic cmd_err;    // request fails at once
      logic need_fall;  // set on a down neighbor, or any disable
      logic tick_down;  // current tick entry went down
   } sts_type;

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CW] ? SAT_MAX : s[CW-1:0];
   endfunction
endpackage

FILE: src/dvrt_ctrl.sv
// Controller state machine of the route table: sequences commands and sweeps.
// Depends on dvrt_pkg.
`timescale 1ns / 1ps
module dvrt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic [2:0]         self_id,
   input  dvrt_pkg::sts_type  sts,
   output dvrt_pkg::ctl_type  ctl,
   output logic               out_load,
   output logic               out_last,
   input  logic               out_free,
   output logic               busy
);
   import dvrt_pkg::*;

   state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic [NW-1:0] fall_ret_ff, fall_ret_in; // tick entry to resume after fallback
   logic tick_fall_ff, tick_fall_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff <= CMD_LOAD;
         idx_ff <= '0;
         fall_ret_ff <= '0;
         tick_fall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmd_ff <= cmd_in;
         idx_ff <= idx_in;
         fall_ret_ff <= fall_ret_in;
         tick_fall_ff <= tick_fall_in;
      end
   end

   always_comb begin
      logic last_idx;
      last_idx = (idx_ff == NW'(NODES-1));
      state_in = state_ff;
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      fall_ret_in = fall_ret_ff;
      tick_fall_in = tick_fall_ff;
      ctl = '0;
      ctl.idx = idx_ff;
      out_load = 1'b0;
      out_last = 1'b1;
      req_ready = 1'b0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch = 1'b1;
               cmd_in = cmd_type'(req_cmd);
               idx_in = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd_ff == CMD_TICK) begin
               state_in = ST_TICK;
            end else if (cmd_ff == CMD_STEP) begin
               state_in = ST_STEP;
               idx_in = (self_id == '0) ? NW'(1) : '0;
            end else begin
               ctl.exec = 1'b1;
               if (sts.cmd_err) begin
                  state_in = ST_OUT;
               end else if (cmd_ff == CMD_ENTRY) begin
                  state_in = ST_RELAX2;
               end else if (sts.need_fall) begin
                  tick_fall_in = 1'b0;
                  idx_in = '0;
                  state_in = ST_FALL;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_RELAX2: begin
            ctl.relax2 = 1'b1;
            state_in = ST_OUT;
         end
         ST_TICK: begin
            ctl.tick_ent = 1'b1;
            if (sts.tick_down) begin
               fall_ret_in = idx_ff;
               tick_fall_in = 1'b1;
               idx_in = '0;
               state_in = ST_FALL;
            end else if (last_idx) begin
               state_in = ST_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FALL: begin
            ctl.fall_ent = 1'b1;
            if (last_idx) begin
               if (tick_fall_ff) begin
                  if (fall_ret_ff == NW'(NODES-1)) begin
                     state_in = ST_OUT;
                  end else begin
                     idx_in = fall_ret_ff + 1'b1;
                     state_in = ST_TICK;
                  end
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_STEP: begin
            out_last = last_idx || (self_id == NW'(NODES-1) && idx_ff == NW'(NODES-2));
            if (out_free) begin
               ctl.step_ent = 1'b1;
               out_load = 1'b1;
               if (out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = ((idx_ff + 1'b1) == self_id) ? idx_ff + NW'(2) : idx_ff + 1'b1;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

FILE: src/dvrt_datapath.sv
// Datapath of the route table: route/neighbor state, relaxation, output register.
// Depends on dvrt_pkg.
`timescale 1ns / 1ps
module dvrt_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_cmd,
   input  logic [2:0]         req_node_id,
   input  logic [15:0]        req_cost,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  dvrt_pkg::ctl_type  ctl,
   output dvrt_pkg::sts_type  sts,
   input  logic               out_load,
   input  logic               out_last,
   output logic               out_free,
   output logic [2:0]         self_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [2:0]         rsp_dest_node,
   output logic [15:0]        rsp_path_cost,
   output logic [2:0]         rsp_next_node,
   output logic               rsp_final_res
);
   import dvrt_pkg::*;

   logic [NW-1:0] self_ff;
   logic [CW-1:0] inf_ff;
   logic [2:0] limit_ff;
   logic [CW-1:0] rcost_ff [NODES];
   logic [NW-1:0] rnext_ff [NODES];
   logic [CW-1:0] kcost_ff [NODES];
   logic [NODES-1:0] nbr_ff, down_ff;
   logic [2:0] sil_ff [NODES];
   logic [NW-1:0] snd_ff;
   logic [CW-1:0] sndc_ff;
   cmd_type cmd_ff;
   logic [NW-1:0] node_ff;
   logic [CW-1:0] cost_ff;
   logic [NW-1:0] fnode_ff; // node whose link went down
   logic [CW-1:0] sum_ff;
   logic [1:0] kind_ff;
   logic err_ff;
   logic ovalid_ff;
   logic [1:0] okind_ff;
   logic [NW-1:0] odest_ff, onext_ff;
   logic [CW-1:0] ocost_ff;
   logic ofin_ff;

   assign self_id = self_ff;

   // Combinational status for the EXEC cycle.
   logic is_err;
   always_comb begin
      is_err = 1'b0;
      unique case (cmd_ff)
         CMD_LOAD: is_err = (node_ff == self_ff);
         CMD_SET, CMD_DISABLE: is_err = !nbr_ff[node_ff];
         default: is_err = 1'b0;
      endcase
   end
   logic [2:0] tick_sil;
   assign tick_sil = (nbr_ff[ctl.idx] && sil_ff[ctl.idx] != 3'd7) ?
                     sil_ff[ctl.idx] + 3'd1 : sil_ff[ctl.idx];
   assign sts.cmd_err = is_err;
   assign sts.need_fall = (cmd_ff == CMD_SET && down_ff[node_ff]) || cmd_ff == CMD_DISABLE;
   assign sts.tick_down = (tick_sil > limit_ff) && nbr_ff[ctl.idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         self_ff <= '0;
         inf_ff <= 16'd9999;
         limit_ff <= 3'd3;
         nbr_ff <= '0;
         down_ff <= '0;
         snd_ff <= '0;
         sndc_ff <= '0;
         for (int i = 0; i < NODES; i++) begin
            rcost_ff[i] <= 16'd9999;
            rnext_ff[i] <= NW'(i);
            kcost_ff[i] <= 16'd9999;
            sil_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            if (csr_index == REG_SELF) self_ff <= csr_wdata[NW-1:0];
            else if (csr_index == REG_INF) inf_ff <= csr_wdata;
            else if (csr_index == REG_LIMIT) limit_ff <= csr_wdata[2:0];
         end
         if (ctl.exec) begin
            unique case (cmd_ff)
               CMD_LOAD: if (!is_err) begin
                  nbr_ff[node_ff] <= 1'b1;
                  down_ff[node_ff] <= 1'b0;
                  sil_ff[node_ff] <= '0;
                  kcost_ff[node_ff] <= cost_ff;
                  rcost_ff[node_ff] <= cost_ff;
                  rnext_ff[node_ff] <= node_ff;
               end
               CMD_HEADER: begin
                  snd_ff <= node_ff;
                  sndc_ff <= (node_ff == self_ff) ? '0 : rcost_ff[node_ff];
                  if (sil_ff[node_ff] != '0) sil_ff[node_ff] <= sil_ff[node_ff] - 3'd1;
               end
               CMD_ENTRY: if (node_ff != self_ff) begin
                  if (rcost_ff[node_ff] > sum_ff) begin
                     rcost_ff[node_ff] <= sum_ff;
                     rnext_ff[node_ff] <= snd_ff;
                     if (!nbr_ff[node_ff]) kcost_ff[node_ff] <= sum_ff;
                  end
               end
               CMD_SET, CMD_DISABLE: begin
                  if (cmd_ff == CMD_DISABLE) down_ff[node_ff] <= 1'b1;
                  if (!is_err) begin
                     kcost_ff[node_ff] <= (cmd_ff == CMD_DISABLE) ? inf_ff : cost_ff;
                     if (rnext_ff[node_ff] == node_ff)
                        rcost_ff[node_ff] <= (cmd_ff == CMD_DISABLE) ? inf_ff : cost_ff;
                  end
               end
               default: ;
            endcase
         end
         if (ctl.relax2 && node_ff != self_ff && rnext_ff[node_ff] == snd_ff
             && node_ff != snd_ff) begin
            if (nbr_ff[node_ff] && kcost_ff[node_ff] <= sum_ff) begin
               rnext_ff[node_ff] <= node_ff;
               rcost_ff[node_ff] <= kcost_ff[node_ff];
            end else begin
               rcost_ff[node_ff] <= sum_ff;
               if (!nbr_ff[node_ff]) kcost_ff[node_ff] <= sum_ff;
            end
         end
         if (ctl.tick_ent) begin
            sil_ff[ctl.idx] <= tick_sil;
            if (tick_sil > limit_ff) begin
               down_ff[ctl.idx] <= 1'b1;
               if (nbr_ff[ctl.idx]) begin
                  kcost_ff[ctl.idx] <= inf_ff;
                  if (rnext_ff[ctl.idx] == ctl.idx) rcost_ff[ctl.idx] <= inf_ff;
               end
            end
         end
         if (ctl.fall_ent && rnext_ff[ctl.idx] == fnode_ff) begin
            rnext_ff[ctl.idx] <= ctl.idx;
            rcost_ff[ctl.idx] <= nbr_ff[ctl.idx] ? kcost_ff[ctl.idx] : inf_ff;
         end
      end
   end

   // Request capture and intermediate sums.
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff <= cmd_type'(req_cmd);
         node_ff <= req_node_id;
         cost_ff <= req_cost;
         fnode_ff <= req_node_id;
      end
      if (ctl.tick_ent) fnode_ff <= ctl.idx;
      if (ctl.exec) begin
         kind_ff <= is_err ? KIND_ERR : (cmd_ff == CMD_READ ? KIND_ROUTE : KIND_ACK);
         err_ff <= is_err;
         // Alternate cost through the sender for the second relax cycle.
         sum_ff <= sat_add(kcost_ff[snd_ff], cost_ff);
      end else if (ctl.latch) begin
         sum_ff <= sat_add(sndc_ff, req_cost);
      end
   end

   // Output register.
   assign out_free = !ovalid_ff || rsp_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (out_load) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_ready) begin
         ovalid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (out_load) begin
         ofin_ff <= out_last;
         if (ctl.step_ent) begin
            okind_ff <= KIND_ADV;
            odest_ff <= ctl.idx;
            ocost_ff <= kcost_ff[ctl.idx];
            onext_ff <= '0;
         end else if (cmd_ff == CMD_TICK) begin
            okind_ff <= KIND_ACK;
            odest_ff <= '0;
            ocost_ff <= '0;
            onext_ff <= '0;
         end else if (cmd_ff == CMD_READ) begin
            okind_ff <= KIND_ROUTE;
            odest_ff <= node_ff;
            ocost_ff <= rcost_ff[node_ff];
            onext_ff <= rnext_ff[node_ff];
         end else begin
            okind_ff <= err_ff ? KIND_ERR : kind_ff;
            odest_ff <= node_ff;
            ocost_ff <= '0;
            onext_ff <= '0;
         end
      end
   end
   assign rsp_valid = ovalid_ff;
   assign rsp_kind = okind_ff;
   assign rsp_dest_node = odest_ff;
   assign rsp_path_cost = ocost_ff;
   assign rsp_next_node = onext_ff;
   assign rsp_final_res = ofin_ff;
endmodule

FILE: src/distance_vector_route_table.sv
// Distance-vector route table for eight nodes. A transaction on the req_
// channel carries one command; every command but step answers one rsp_
// transaction, step answers one advertised entry per node other than self.
// Load, header, read and a set cost on a live link execute, then answer; an
// entry adds the second half of its relaxation first; set cost on a down link
// and disable add a fallback sweep over the table; tick walks the eight
// entries one per cycle, broken off by a fallback sweep for every neighbor
// that goes silent, after which the walk resumes at the following entry.
// Step sends its advertised entries one at a time as the output register frees.
// Configuration writes on the csr_ port must only be made while no
// transaction is in flight.
// Depends on dvrt_pkg, dvrt_ctrl, dvrt_datapath and the defines header.
`timescale 1ns / 1ps
`include "distance_vector_route_table_defines.svh"
module distance_vector_route_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [2:0]  req_node_id,
   input  logic [15:0] req_cost,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_dest_node,
   output logic [15:0] rsp_path_cost,
   output logic [2:0]  rsp_next_node,
   output logic        rsp_final_res,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import dvrt_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic out_load, out_last, out_free, busy;
   logic [2:0] self_id;

   dvrt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .self_id(self_id), .sts(sts), .ctl(ctl),
      .out_load(out_load), .out_last(out_last), .out_free(out_free), .busy(busy)
   );

   dvrt_datapath u_dp (
      .clock(clock), .reset(reset), .req_cmd(req_cmd), .req_node_id(req_node_id),
      .req_cost(req_cost), .csr_write(csr_write), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .ctl(ctl), .sts(sts), .out_load(out_load),
      .out_last(out_last), .out_free(out_free), .self_id(self_id),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_dest_node(rsp_dest_node), .rsp_path_cost(rsp_path_cost),
      .rsp_next_node(rsp_next_node), .rsp_final_res(rsp_final_res)
   );

   // A new request is only taken when the controller is idle.
   `DVRT_ASSERT(a_ready_idle, clock, reset, req_ready |-> !busy, "ready while busy")
   // A result is only loaded when the output register can take it.
   `DVRT_ASSERT(a_load_free, clock, reset, out_load |-> out_free, "output overrun")
   // Only one table action per cycle.
   `DVRT_ASSERT(a_one_action, clock, reset,
      $onehot0({ctl.exec, ctl.relax2, ctl.tick_ent, ctl.fall_ent, ctl.step_ent}),
      "overlapping table actions")
   // After reset the result channel is quiet.
   `DVRT_ASSERT_NR(a_reset_quiet, clock, reset |=> !rsp_valid, "valid after reset")
endmodule

FILE: verif/distance_vector_route_table_checker.sv
// Checker for the distance-vector route table: watches both channels and the csr_ port,
// keeps its own copy of the routing state, predicts each response and compares.
// Depends on dvrt_pkg.
`timescale 1ns / 1ps
module distance_vector_route_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [2:0]  req_node_id,
   input  logic [15:0] req_cost,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic [2:0]  rsp_dest_node,
   input  logic [15:0] rsp_path_cost,
   input  logic [2:0]  rsp_next_node,
   input  logic        rsp_final_res,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          rsp_count
);
   import dvrt_pkg::*;

   typedef struct packed {
      kind_type     kind;
      logic [2:0]   dest;
      logic [15:0]  cost;
      logic [2:0]   next;
      logic         fin;
   } answer_type;

   answer_type answers_due[$];

   logic [2:0]  own_node;
   logic [15:0] unreachable;
   logic [2:0]  quiet_limit;
   logic [15:0] best_cost [NODES];
   logic [2:0]  best_hop [NODES];
   logic [15:0] link_cost [NODES];
   logic        is_neighbor [NODES];
   logic        is_down [NODES];
   logic [2:0]  quiet_ticks [NODES];
   logic [2:0]  adv_sender;
   logic [15:0] adv_base;

   function automatic logic [15:0] capped_sum(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   task automatic clear_table();
      for (int i = 0; i < NODES; i++) begin
         best_cost[i] = unreachable;
         best_hop[i] = i[2:0];
         link_cost[i] = unreachable;
         is_neighbor[i] = 1'b0;
         is_down[i] = 1'b0;
         quiet_ticks[i] = 3'd0;
      end
      adv_sender = 3'd0;
      adv_base = 16'd0;
   endtask

   function automatic bit apply_link(int n, logic [15:0] c);
      if (!is_neighbor[n])
         return 1'b0;
      link_cost[n] = c;
      if (best_hop[n] == n[2:0])
         best_cost[n] = c;
      if (is_down[n]) begin
         for (int j = 0; j < NODES; j++) begin
            if (best_hop[j] == n[2:0]) begin
               best_hop[j] = j[2:0];
               best_cost[j] = is_neighbor[j] ? link_cost[j] : unreachable;
            end
         end
      end
      return 1'b1;
   endfunction

   task automatic relax_entry(int d, logic [15:0] c);
      logic [15:0] total;
      logic [15:0] alt;
      total = capped_sum(adv_base, c);
      if (best_cost[d] > total) begin
         best_cost[d] = total;
         best_hop[d] = adv_sender;
         if (!is_neighbor[d])
            link_cost[d] = total;
      end
      if (best_hop[d] == adv_sender && d != adv_sender) begin
         alt = capped_sum(link_cost[adv_sender], c);
         if (is_neighbor[d] && link_cost[d] <= alt) begin
            best_hop[d] = d[2:0];
            best_cost[d] = link_cost[d];
         end else begin
            best_cost[d] = alt;
            if (!is_neighbor[d])
               link_cost[d] = alt;
         end
      end
   endtask

   task automatic push(kind_type k, int d, logic [15:0] c, int nx, bit f);
      answer_type a;
      a.kind = k;
      a.dest = d[2:0];
      a.cost = c;
      a.next = nx[2:0];
      a.fin = f;
      answers_due.push_back(a);
   endtask

   task automatic predict_command(cmd_type cmd, int n, logic [15:0] c);
      int k;
      case (cmd)
         CMD_LOAD: begin
            if (n == own_node) begin
               push(KIND_ERR, n, 16'd0, 0, 1'b1);
               return;
            end
            is_neighbor[n] = 1'b1;
            is_down[n] = 1'b0;
            quiet_ticks[n] = 3'd0;
            link_cost[n] = c;
            best_cost[n] = c;
            best_hop[n] = n[2:0];
         end
         CMD_HEADER: begin
            adv_sender = n[2:0];
            adv_base = (n == own_node) ? 16'd0 : best_cost[n];
            if (quiet_ticks[n] > 0)
               quiet_ticks[n]--;
         end
         CMD_ENTRY: begin
            if (n != own_node)
               relax_entry(n, c);
         end
         CMD_SET, CMD_DISABLE: begin
            if (cmd == CMD_DISABLE) begin
               is_down[n] = 1'b1;
               c = unreachable;
            end
            if (!apply_link(n, c)) begin
               push(KIND_ERR, n, 16'd0, 0, 1'b1);
               return;
            end
         end
         CMD_TICK: begin
            for (int i = 0; i < NODES; i++) begin
               if (is_neighbor[i] && quiet_ticks[i] < 3'd7)
                  quiet_ticks[i]++;
               if (quiet_ticks[i] > quiet_limit) begin
                  is_down[i] = 1'b1;
                  void'(apply_link(i, unreachable));
               end
            end
            push(KIND_ACK, 0, 16'd0, 0, 1'b1);
            return;
         end
         CMD_STEP: begin
            k = 0;
            for (int i = 0; i < NODES; i++) begin
               if (i != own_node) begin
                  k++;
                  push(KIND_ADV, i, link_cost[i], 0, k == NODES - 1);
               end
            end
            return;
         end
         default: begin
            push(KIND_ROUTE, n, best_cost[n], int'(best_hop[n]), 1'b1);
            return;
         end
      endcase
      push(KIND_ACK, n, 16'd0, 0, 1'b1);
   endtask

   task automatic report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      rsp_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      answer_type w;
      if (reset) begin
         own_node = 3'd0;
         unreachable = 16'd9999;
         quiet_limit = 3'd3;
         clear_table();
         answers_due.delete();
      end else begin
         // A response and a request may both complete at this edge; the response
         // always belongs to an earlier request, so check it first.
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (answers_due.size() == 0) begin
               report("unexpected transaction, kind", 16'(rsp_kind), 16'd0);
            end else begin
               w = answers_due.pop_front();
               if (rsp_kind != w.kind)
                  report("kind", 16'(rsp_kind), 16'(w.kind));
               if (rsp_dest_node != w.dest)
                  report("dest_node", 16'(rsp_dest_node), 16'(w.dest));
               if (rsp_path_cost != w.cost)
                  report("path_cost", rsp_path_cost, w.cost);
               if (rsp_next_node != w.next)
                  report("next_node", 16'(rsp_next_node), 16'(w.next));
               if (rsp_final_res != w.fin)
                  report("final_res", 16'(rsp_final_res), 16'(w.fin));
            end
         end
         if (req_valid && req_ready)
            predict_command(cmd_type'(req_cmd), int'(req_node_id), req_cost);
         if (csr_write) begin
            case (csr_index)
               REG_SELF: own_node = csr_wdata[2:0];
               REG_INF: unreachable = csr_wdata;
               REG_LIMIT: quiet_limit = csr_wdata[2:0];
               default: ;
            endcase
         end
      end
      pending_count = answers_due.size();
   end
endmodule

FILE: verif/distance_vector_route_table_test.sv
// Top of the route table testbench: clock, reset, command stimulus and csr_ writes.
// Checking is done by distance_vector_route_table_checker; depends on dvrt_pkg, the checker and the DUT.
`timescale 1ns / 1ps
module distance_vector_route_table_test;
   import dvrt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_cmd = '0;
   logic [2:0]  req_node_id = '0;
   logic [15:0] req_cost = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_dest_node;
   logic [15:0] rsp_path_cost;
   logic [2:0]  rsp_next_node;
   logic        rsp_final_res;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int fail_count;
   int pending_count;
   int rsp_count;
   int cycle_count = 0;
   int sent_count = 0;
   // The receiver holds off for a long stretch while this is set.
   bit hold_rsp = 1'b0;
   bit stall_free = 1'b0;

   localparam int CYCLE_LIMIT = 400000;
   // A register index that the block does not implement.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   always #4 clock = ~clock;

   distance_vector_route_table DUT (.*);

   distance_vector_route_table_checker checker_i (.*);

   // Pick a gap: usually none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (stall_free || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The response side stalls at random, on its own schedule.
   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else begin
            g = pick_gap();
            if (g == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (g - 1) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // The request is dropped at the falling edge after acceptance, so the next
   // one is driven no earlier than the falling edge after that.
   task automatic send(cmd_type cmd, int n, logic [15:0] c);
      repeat (1 + pick_gap()) @(negedge clock);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_node_id <= n[2:0];
      req_cost <= c;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait out every expected response, then let a full tick sweep finish.
   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [15:0] random_cost();
      case ($urandom_range(0, 5))
         0: return 16'hFFFF;
         1: return 16'd0;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, 40));
      endcase
   endfunction

   // One well-formed advertisement: a header followed by a handful of entries.
   task automatic advertise();
      send(CMD_HEADER, $urandom_range(0, 7), 16'($urandom));
      repeat ($urandom_range(1, 5))
         send(CMD_ENTRY, $urandom_range(0, 7), random_cost());
   endtask

   task automatic random_phase(int items);
      int r;
      int stop_at;
      stop_at = sent_count + items;
      while (sent_count < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 45) advertise();
         else if (r < 55) send(CMD_LOAD, $urandom_range(0, 7), random_cost());
         else if (r < 63) send(CMD_SET, $urandom_range(0, 7), random_cost());
         else if (r < 68) send(CMD_DISABLE, $urandom_range(0, 7), 16'($urandom));
         else if (r < 78) send(CMD_TICK, $urandom_range(0, 7), 16'($urandom));
         else if (r < 85) send(CMD_STEP, $urandom_range(0, 7), 16'($urandom));
         else send(CMD_READ, $urandom_range(0, 7), 16'($urandom));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with reset configuration: a load of self is refused,
      // commands on non-neighbors give errors, and cost extremes are relaxed.
      stall_free = 1'b1;
      send(CMD_LOAD, 0, 16'd5);
      send(CMD_LOAD, 1, 16'd0);
      send(CMD_LOAD, 7, 16'hFFFF);
      send(CMD_LOAD, 2, 16'd3);
      send(CMD_SET, 5, 16'd4);
      send(CMD_DISABLE, 6, 16'd0);
      send(CMD_HEADER, 2, 16'hAAAA);
      send(CMD_ENTRY, 5, 16'd10);
      send(CMD_ENTRY, 0, 16'd1);
      send(CMD_ENTRY, 7, 16'hFFFF);
      send(CMD_HEADER, 7, 16'h5555);
      send(CMD_ENTRY, 3, 16'hFFFF);
      send(CMD_HEADER, 0, 16'd0);
      send(CMD_ENTRY, 4, 16'd2);
      send(CMD_READ, 5, 16'd0);
      send(CMD_READ, 7, 16'hFFFF);
      send(CMD_SET, 2, 16'd100);
      send(CMD_DISABLE, 2, 16'd0);
      send(CMD_READ, 5, 16'd0);
      send(CMD_STEP, 0, 16'd0);
      repeat (5) send(CMD_TICK, 0, 16'd0);
      send(CMD_READ, 1, 16'd0);
      stall_free = 1'b0;
      drain();

      // Long receiver hold-off while commands keep coming, so the block backs up.
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         random_phase(12);
      join
      drain();

      // Extreme settings: highest self, a tiny infinity and a limit of one.
      write_reg(REG_SELF, 16'd7);
      write_reg(REG_INF, 16'd1);
      write_reg(REG_LIMIT, 16'd1);
      write_reg(REG_UNUSED, 16'hFFFF);
      random_phase(80);
      drain();

      // The other extremes: largest infinity and longest limit.
      write_reg(REG_SELF, 16'd0);
      write_reg(REG_INF, 16'hFFFF);
      write_reg(REG_LIMIT, 16'd7);
      random_phase(80);
      drain();

      write_reg(REG_SELF, 16'd3);
      write_reg(REG_INF, 16'd9999);
      write_reg(REG_LIMIT, 16'd3);
      random_phase(80);
      drain();

      $display("Sent %0d commands and checked %0d responses over four settings,",
               sent_count, rsp_count);
      $display("including a long receiver stall and saturating cost sums.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
